// ===== src/ffra_pkg.sv =====
// ffra_pkg: shared types and codes for the first-fit allocator
// depends on nothing; used by ffra_ctrl, ffra_dp and the top level
package ffra_pkg;

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_ADDREF = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam int START_W = 16;
	localparam int SIZE_W  = 16;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,       // latch the request
		OP_FSCAN,      // test free entry at index
		OP_FTAKE,      // shrink hit free entry, append held entry
		OP_HSCAN,      // test held entry at index
		OP_DEC,        // decrement count
		OP_INC,        // saturating increment
		OP_FSHIFT,     // move free entry idx-1 to idx
		OP_FPUSH,      // write removed block to free entry 0
		OP_HSHIFT,     // move held entry idx+1 to idx
		OP_SUM,        // add free size at index to total
		OP_FCLR,       // set free table to a single block
		OP_REPACK      // restart held entry at index
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [8:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       free_hit;   // free size at index >= request
		logic       held_hit;   // held start at index == address
		logic       count_gt1;
		logic [8:0] free_used;
		logic [8:0] held_used;
		logic [8:0] found;
	} dp_stat_t;

endpackage

// ===== src/first_fit_refcount_allocator.sv =====
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | command[1:0], request_bytes[11:2], block_address[18:12], pad to 24
// m_axis  | out | status[1:0], result_address[8:2], count_after[16:9], pad to 24
// an item is loaded and dispatched, then free or held entries are tested one by one;
// a found free or add reference then updates the count; a free of the last reference
// shifts the free table up from free_used, pushes the block to free entry 0 and
// shifts held entries from the found one to the end; a no-fit ends the scan, sums
// the free sizes, clears the free table to one block and repacks every held entry
// arst_n resets counters, the free table (entry 0 to the whole heap) and handshake; held table is not cleared
// the result register holds one item; a new item waits until it is taken
// top level; depends on ffra_pkg, ffra_ctrl, ffra_dp
module first_fit_refcount_allocator #(
	parameter int HEAP_WORDS = 128,
	parameter int FREE_SLOTS = 32,
	parameter int HELD_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // command, request_bytes, block_address
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // status, result_address, count_after
);
	import ffra_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [1:0] set_status, status;
	logic set_result, busy, done, start;
	logic [6:0] result_address;
	logic [7:0] count_after;

	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = done;
	assign m_axis_tdata = {7'd0, count_after, result_address, status};

	ffra_ctrl #(.FREE_SLOTS(FREE_SLOTS), .HELD_SLOTS(HELD_SLOTS)) u_ctrl (
		.clk, .arst_n, .start, .out_free(m_axis_tready), .stat, .cmd,
		.set_status, .set_result, .busy, .done
	);

	ffra_dp #(.HEAP_WORDS(HEAP_WORDS), .FREE_SLOTS(FREE_SLOTS),
		.HELD_SLOTS(HELD_SLOTS)) u_dp (
		.clk, .arst_n, .cmd, .in_command(s_axis_tdata[1:0]),
		.in_bytes(s_axis_tdata[11:2]), .in_address(s_axis_tdata[18:12]),
		.set_status, .set_result, .stat, .status, .result_address, .count_after
	);

	// no new item while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept with pending result");
	// held count stays in range
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.held_used <= 9'(HELD_SLOTS)) else $error("held count overflow");
	// free count stays in range
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.free_used <= 9'(FREE_SLOTS) && stat.free_used != 9'd0)
		else $error("free count out of range");

endmodule

// ===== src/ffra_dp.sv =====
// ffra_dp: free and held tables, counters and result registers
// depends on ffra_pkg
module ffra_dp #(
	parameter int HEAP_WORDS = 128,
	parameter int FREE_SLOTS = 32,
	parameter int HELD_SLOTS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffra_pkg::dp_cmd_t   cmd,
	input  logic [1:0]          in_command,
	input  logic [9:0]          in_bytes,
	input  logic [6:0]          in_address,
	input  logic [1:0]          set_status,
	input  logic                set_result,
	output ffra_pkg::dp_stat_t  stat,
	output logic [1:0]          status,
	output logic [6:0]          result_address,
	output logic [7:0]          count_after
);
	import ffra_pkg::*;

	localparam int FI_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int HI_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

	logic [START_W-1:0] free_starts_q [FREE_SLOTS];
	logic [SIZE_W-1:0]  free_sizes_q  [FREE_SLOTS];
	logic [START_W-1:0] held_starts_q [HELD_SLOTS];
	logic [9:0]         held_sizes_q  [HELD_SLOTS];
	logic [7:0]         held_counts_q [HELD_SLOTS];
	logic [8:0]         free_used_q, held_used_q, found_q;
	logic [1:0]         command_q;
	logic [9:0]         bytes_q;
	logic [6:0]         addr_q;
	logic [START_W-1:0] next_q;
	logic [SIZE_W-1:0]  total_q;
	logic [1:0]         status_q;
	logic [6:0]         raddr_q;
	logic [7:0]         cnt_q;

	logic [FI_W-1:0] fi, fim1;
	logic [HI_W-1:0] hi, hip1, hf, hu;
	logic [SIZE_W-1:0] sum;

	assign fi   = cmd.idx[FI_W-1:0];
	assign fim1 = fi - 1'b1;
	assign hi   = cmd.idx[HI_W-1:0];
	assign hip1 = hi + 1'b1;
	assign hf   = found_q[HI_W-1:0];
	assign hu   = held_used_q[HI_W-1:0];
	assign sum  = total_q + free_sizes_q[fi];

	// status toward the controller
	always_comb begin
		stat.command   = command_q;
		stat.free_hit  = free_sizes_q[fi] >= SIZE_W'(bytes_q);
		stat.held_hit  = held_starts_q[hi] == START_W'(addr_q);
		stat.count_gt1 = held_counts_q[hf] > 8'd1;
		stat.free_used = free_used_q;
		stat.held_used = held_used_q;
		stat.found     = found_q;
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_used_q <= 9'd1;
			held_used_q <= 9'd0;
			found_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_FTAKE: held_used_q <= held_used_q + 9'd1;
				OP_FPUSH: free_used_q <= free_used_q + 9'd1;
				OP_HSHIFT: if (9'(cmd.idx) + 9'd1 >= held_used_q)
					held_used_q <= held_used_q - 9'd1;
				OP_FCLR: free_used_q <= 9'd1;
				OP_HSCAN: found_q <= cmd.idx;
				default: ;
			endcase
		end
	end

	// free table: entry 0 resets to the whole heap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FREE_SLOTS; i++) begin
				free_starts_q[i] <= '0;
				free_sizes_q[i] <= '0;
			end
			free_sizes_q[0] <= SIZE_W'(HEAP_WORDS * 4);
		end else begin
			unique case (cmd.op)
				OP_FTAKE: begin
					free_sizes_q[fi] <= free_sizes_q[fi] - SIZE_W'(bytes_q);
					free_starts_q[fi] <= free_starts_q[fi] + START_W'((bytes_q + 10'd3) >> 2);
				end
				OP_FSHIFT: begin
					free_starts_q[fi] <= free_starts_q[fim1];
					free_sizes_q[fi] <= free_sizes_q[fim1];
				end
				OP_FPUSH: begin
					free_starts_q[0] <= held_starts_q[hf];
					free_sizes_q[0] <= SIZE_W'(held_sizes_q[hf]);
				end
				OP_FCLR: begin
					for (int i = 0; i < FREE_SLOTS; i++) begin
						free_starts_q[i] <= '0;
						free_sizes_q[i] <= '0;
					end
					free_sizes_q[0] <= total_q;
				end
				default: ;
			endcase
		end
	end

	// held table, request and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				command_q <= in_command;
				bytes_q <= in_bytes;
				addr_q <= in_address;
				total_q <= '0;
			end
			OP_FTAKE: begin
				held_starts_q[hu] <= free_starts_q[fi];
				held_sizes_q[hu] <= bytes_q;
				held_counts_q[hu] <= 8'd1;
				raddr_q <= free_starts_q[fi][6:0];
				cnt_q <= 8'd1;
			end
			OP_DEC: begin
				held_counts_q[hf] <= held_counts_q[hf] - 8'd1;
				cnt_q <= held_counts_q[hf] - 8'd1;
			end
			OP_INC: begin
				if (held_counts_q[hf] != 8'hFF)
					held_counts_q[hf] <= held_counts_q[hf] + 8'd1;
				cnt_q <= (held_counts_q[hf] != 8'hFF) ? held_counts_q[hf] + 8'd1 : 8'hFF;
			end
			OP_HSHIFT: if (9'(cmd.idx) + 9'd1 < held_used_q) begin
				held_starts_q[hi] <= held_starts_q[hip1];
				held_sizes_q[hi] <= held_sizes_q[hip1];
				held_counts_q[hi] <= held_counts_q[hip1];
			end
			OP_SUM: total_q <= sum;
			OP_FCLR: next_q <= START_W'((total_q + SIZE_W'(3)) >> 2);
			OP_REPACK: begin
				held_starts_q[hi] <= next_q;
				next_q <= next_q + START_W'((held_sizes_q[hi] + 10'd3) >> 2);
			end
			default: ;
		endcase
		if (set_result) begin
			status_q <= set_status;
			if (set_status == ST_OK && command_q != CMD_ALLOC)
				raddr_q <= addr_q;
			else if (set_status != ST_OK)
				raddr_q <= (command_q == CMD_ALLOC) ? 7'd0 : addr_q;
			if (set_status == ST_OK && command_q == CMD_FREE && cmd.op == OP_HSHIFT)
				cnt_q <= 8'd0;
			else if (set_status == ST_FULL && command_q == CMD_FREE)
				cnt_q <= held_counts_q[hf];
			else if (set_status != ST_OK)
				cnt_q <= 8'd0;
		end
	end

	assign status = status_q;
	assign result_address = raddr_q;
	assign count_after = cnt_q;

endmodule

// ===== src/ffra_ctrl.sv =====
// ffra_ctrl: sequencer stepping through table scans and updates
// depends on ffra_pkg
module ffra_ctrl #(
	parameter int FREE_SLOTS = 32,
	parameter int HELD_SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               out_free,
	input  ffra_pkg::dp_stat_t stat,
	output ffra_pkg::dp_cmd_t  cmd,
	output logic [1:0]         set_status,
	output logic               set_result,
	output logic               busy,
	output logic               done
);
	import ffra_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_FSCAN, S_HSCAN, S_ACT, S_FSHIFT, S_HSHIFT,
		S_SUM, S_REPACK, S_WAIT
	} state_t;

	state_t state_q;
	logic [8:0] idx_q;

	// command decode per state
	always_comb begin
		cmd.op = OP_NONE;
		cmd.idx = idx_q;
		set_result = 1'b0;
		set_status = ST_OK;
		unique case (state_q)
			S_IDLE: if (start) cmd.op = OP_LOAD;
			S_DISPATCH: begin
				if (stat.command == CMD_ALLOC) begin
					if (stat.held_used >= 9'(HELD_SLOTS)) begin
						set_result = 1'b1;
						set_status = ST_FULL;
					end
				end else if (stat.command == CMD_FREE || stat.command == CMD_ADDREF) begin
					if (stat.held_used == 9'd0) begin
						set_result = 1'b1;
						set_status = ST_NOTFOUND;
					end
				end else begin
					set_result = 1'b1;
					set_status = ST_NOTFOUND;
				end
			end
			S_FSCAN: if (idx_q >= stat.free_used || idx_q >= 9'(FREE_SLOTS))
					cmd.op = OP_NONE;
				else if (stat.free_hit) begin
					cmd.op = OP_FTAKE;
					set_result = 1'b1;
				end
			S_HSCAN: if (stat.held_hit) cmd.op = OP_HSCAN;
				else if (idx_q + 9'd1 >= stat.held_used) begin
					set_result = 1'b1;
					set_status = ST_NOTFOUND;
				end
			S_ACT: if (stat.command == CMD_ADDREF) begin
					cmd.op = OP_INC;
					set_result = 1'b1;
				end else if (stat.count_gt1) begin
					cmd.op = OP_DEC;
					set_result = 1'b1;
				end else if (stat.free_used >= 9'(FREE_SLOTS)) begin
					set_result = 1'b1;
					set_status = ST_FULL;
				end
			S_FSHIFT: cmd.op = (idx_q == 9'd0) ? OP_FPUSH : OP_FSHIFT;
			S_HSHIFT: begin
				cmd.op = OP_HSHIFT;
				if (idx_q + 9'd1 >= stat.held_used) set_result = 1'b1;
			end
			S_SUM: cmd.op = (idx_q < stat.free_used && idx_q < 9'(FREE_SLOTS)) ? OP_SUM : OP_FCLR;
			S_REPACK: if (idx_q < stat.held_used) cmd.op = OP_REPACK;
				else begin
					set_result = 1'b1;
					set_status = ST_NOFIT;
				end
			S_WAIT: ;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			done <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					idx_q <= '0;
					if (set_result) begin
						state_q <= S_WAIT;
						done <= 1'b1;
					end else if (stat.command == CMD_ALLOC) state_q <= S_FSCAN;
					else state_q <= S_HSCAN;
				end
				S_FSCAN: if (cmd.op == OP_FTAKE) begin
						state_q <= S_WAIT;
						done <= 1'b1;
					end else if (idx_q >= stat.free_used || idx_q >= 9'(FREE_SLOTS)) begin
						idx_q <= '0;
						state_q <= S_SUM;
					end else idx_q <= idx_q + 9'd1;
				S_HSCAN: if (cmd.op == OP_HSCAN) state_q <= S_ACT;
					else if (set_result) begin
						state_q <= S_WAIT;
						done <= 1'b1;
					end else idx_q <= idx_q + 9'd1;
				S_ACT: if (set_result) begin
						state_q <= S_WAIT;
						done <= 1'b1;
					end else begin
						idx_q <= stat.free_used;
						state_q <= S_FSHIFT;
					end
				S_FSHIFT: if (idx_q == 9'd0) begin
						idx_q <= stat.found;
						state_q <= S_HSHIFT;
					end else idx_q <= idx_q - 9'd1;
				S_HSHIFT: if (set_result) begin
						state_q <= S_WAIT;
						done <= 1'b1;
					end else idx_q <= idx_q + 9'd1;
				S_SUM: if (cmd.op == OP_FCLR) begin
						idx_q <= '0;
						state_q <= S_REPACK;
					end else idx_q <= idx_q + 9'd1;
				S_REPACK: if (set_result) begin
						state_q <= S_WAIT;
						done <= 1'b1;
					end else idx_q <= idx_q + 9'd1;
				// result item taken, back to idle
				S_WAIT: if (!done || out_free) begin
						state_q <= S_IDLE;
						done <= 1'b0;
					end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
